[rtl/assert_macros.svh]
// Assertion macros shared by the value noise RTL.
// Depends on nothing; expects aclk and aresetn in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define VN_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define VN_ASSERT(lbl, prop, msg)
`define VN_NEVER(lbl, cond, msg)
`endif
`endif

[rtl/vn2c_pkg.sv]
// Shared constants, cosine table builder and blend function for value noise.
// Depends on nothing.
package vn2c_pkg;

    localparam int ROM_DEPTH = 1024;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);
    localparam int COORD_W   = 20;
    localparam int FREQ_W    = 4;
    localparam int FRAC_W    = 15;
    localparam int NOISE_W   = 8;
    localparam int COS_W     = 18;
    localparam int WGT_W     = 17;
    localparam int QF        = 58;
    localparam logic [63:0] P5 = 64'd9765625;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 4'd2;

    typedef logic signed [COS_W-1:0] cos_table_t [ROM_DEPTH];

    // Fixed-point product (a*b) >> QF, keep 64 bits
    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[QF+63:QF];
    endfunction

    // Shift-subtract quotient n / d for the table build
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Truncated 65536*cos(i*0.0030679615) from a Q58 Taylor series
    function automatic logic signed [COS_W-1:0] cos_entry(input int i);
        logic [63:0] num, q1, r1, ang, a2, term, pos, neg, den, diff;
        num  = 64'(i) * 64'd30679615;
        q1   = (num << 20) / P5;
        r1   = (num << 20) % P5;
        ang  = (q1 << 28) + ((r1 << 28) / P5);
        a2   = qmul(ang, ang);
        term = 64'd1 << QF;
        pos  = term;
        neg  = 64'd0;
        for (int k = 1; k < 48; k++) begin
            den  = 64'((2 * k - 1) * (2 * k));
            term = udiv64(qmul(term, a2), den);
            if (k % 2 == 1) neg = neg + term;
            else pos = pos + term;
        end
        if (pos >= neg) begin
            diff = (pos - neg) >> (QF - 16);
            return COS_W'(diff);
        end
        diff = (neg - pos) >> (QF - 16);
        return -COS_W'(diff);
    endfunction

    function automatic cos_table_t build_cos_table();
        cos_table_t t;
        for (int i = 0; i < ROM_DEPTH; i++) t[i] = cos_entry(i);
        return t;
    endfunction

    // Cosine weight (65536 - c) / 2 from a table entry
    function automatic logic [WGT_W-1:0] cos_weight(input logic signed [COS_W-1:0] c);
        logic signed [COS_W:0] d;
        d = (COS_W+1)'(65536) - (COS_W+1)'(c);
        return d[WGT_W:1];
    endfunction

    // Blend a toward b by weight w in 1.16
    function automatic logic [NOISE_W-1:0] blend(input logic [NOISE_W-1:0] a,
                                                 input logic [NOISE_W-1:0] b,
                                                 input logic [WGT_W-1:0] w);
        logic [WGT_W+NOISE_W-1:0] pb, pa;
        logic [NOISE_W:0]         s;
        pb = (WGT_W+NOISE_W)'(w) * (WGT_W+NOISE_W)'(b);
        pa = (WGT_W+NOISE_W)'(WGT_W'(65536) - w) * (WGT_W+NOISE_W)'(a);
        s  = (NOISE_W+1)'(pb >> 16) + (NOISE_W+1)'(pa >> 16);
        return s[NOISE_W-1:0];
    endfunction

endpackage

[rtl/value_noise_2d_cosine_core.sv]
// Top level of the 2D cosine-interpolated value noise core.
// Depends on vn2c_pkg, vn2c_hash, vn2c_cos_rom and assert_macros.svh.
//
//  channel | direction | signals
//  s_      | in        | s_valid, s_ready, s_coord_x[19:0], s_coord_y[19:0]
//  m_      | out       | m_valid, m_ready, m_noise_value[7:0]
//  cfg_    | in        | cfg_valid, cfg_ready, cfg_data[3:0] (freq_log2)
//
// One beat per cycle unless the output is held; eight register stages, so a beat accepted
// passes through each stage in turn before it sits in the output register.
// Stages: split, hash index, square, polynomial, hash, smooth, x blend, y blend.
// The three hash multiplies and the cosine ROM read set the stage boundaries.
// Reset clears stage valid bits and sets freq_log2 to 2; the ROM is fixed.
// A held output stalls every stage at once; nothing is dropped or repeated.
`include "assert_macros.svh"

module value_noise_2d_cosine_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [vn2c_pkg::COORD_W-1:0]       s_coord_x,
    input  logic [vn2c_pkg::COORD_W-1:0]       s_coord_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [vn2c_pkg::NOISE_W-1:0]       m_noise_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vn2c_pkg::FREQ_W-1:0]        cfg_data
);
    localparam int NSTG = 8;
    localparam int NW   = vn2c_pkg::NOISE_W;
    localparam int WW   = vn2c_pkg::WGT_W;

    logic en;
    logic [NSTG-1:0] vld_reg, vld_next;
    logic [vn2c_pkg::FREQ_W-1:0] freq_reg;

    // Split coordinates into cell and fraction
    logic [vn2c_pkg::COORD_W-1:0] cx_next, cy_next, cx_reg, cy_reg;
    logic [vn2c_pkg::FRAC_W-1:0]  fx, fy, fmask;
    logic [vn2c_pkg::FRAC_W+vn2c_pkg::ROM_AW-1:0] ix_wide, iy_wide;
    logic [vn2c_pkg::ROM_AW-1:0]  ix_reg, iy_reg;

    assign fmask   = vn2c_pkg::FRAC_W'((32'd1 << freq_reg) - 32'd1);
    assign cx_next = s_coord_x >> freq_reg;
    assign cy_next = s_coord_y >> freq_reg;
    assign fx      = s_coord_x[vn2c_pkg::FRAC_W-1:0] & fmask;
    assign fy      = s_coord_y[vn2c_pkg::FRAC_W-1:0] & fmask;
    assign ix_wide = {fx, {vn2c_pkg::ROM_AW{1'b0}}} >> freq_reg;
    assign iy_wide = {fy, {vn2c_pkg::ROM_AW{1'b0}}} >> freq_reg;

    // Global advance: output register free or being taken
    assign en        = !vld_reg[NSTG-1] || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;
    assign vld_next  = {vld_reg[NSTG-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            freq_reg <= vn2c_pkg::FREQ_RESET;
        end else begin
            if (en) vld_reg <= vld_next;
            if (cfg_valid && cfg_ready) freq_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            ix_reg <= ix_wide[vn2c_pkg::ROM_AW-1:0];
            iy_reg <= iy_wide[vn2c_pkg::ROM_AW-1:0];
        end
    end

    // Hash the 4x4 lattice around the cell
    logic [NW-1:0] grid [4][4];

    for (genvar j = 0; j < 4; j++) begin : g_row
        for (genvar i = 0; i < 4; i++) begin : g_col
            vn2c_hash u_hash (
                .aclk (aclk),
                .en   (en),
                .px   (32'(cx_reg) + 32'(i) - 32'd1),
                .py   (32'(cy_reg) + 32'(j) - 32'd1),
                .hash (grid[j][i])
            );
        end
    end

    // Look up cosine weights
    logic signed [vn2c_pkg::COS_W-1:0] cos_x, cos_y;

    vn2c_cos_rom u_rom (
        .aclk   (aclk),
        .en     (en),
        .addr_a (ix_reg),
        .addr_b (iy_reg),
        .data_a (cos_x),
        .data_b (cos_y)
    );

    // Carry weights alongside the hash stages
    logic [WW-1:0] wx_reg [4];
    logic [WW-1:0] wy_reg [5];

    always_ff @(posedge aclk) begin
        if (en) begin
            wx_reg[0] <= vn2c_pkg::cos_weight(cos_x);
            wy_reg[0] <= vn2c_pkg::cos_weight(cos_y);
            for (int k = 1; k < 4; k++) wx_reg[k] <= wx_reg[k-1];
            for (int k = 1; k < 5; k++) wy_reg[k] <= wy_reg[k-1];
        end
    end

    // Smooth the four cell corners over their 3x3 neighborhoods
    logic [NW-1:0] v_next [4];
    logic [NW-1:0] v_reg  [4];

    always_comb begin
        logic [NW+1:0] cs, sd;
        int ci, cj;
        for (int c = 0; c < 4; c++) begin
            ci = 1 + (c % 2);
            cj = 1 + (c / 2);
            cs = (NW+2)'(grid[cj-1][ci-1]) + (NW+2)'(grid[cj-1][ci+1])
               + (NW+2)'(grid[cj+1][ci-1]) + (NW+2)'(grid[cj+1][ci+1]);
            sd = (NW+2)'(grid[cj][ci-1]) + (NW+2)'(grid[cj][ci+1])
               + (NW+2)'(grid[cj-1][ci]) + (NW+2)'(grid[cj+1][ci]);
            v_next[c] = NW'(cs >> 4) + NW'(sd >> 3) + NW'(grid[cj][ci] >> 2);
        end
    end

    // Blend along x, then along y
    logic [NW-1:0] i1_reg, i2_reg, out_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) v_reg[c] <= v_next[c];
            i1_reg  <= vn2c_pkg::blend(v_reg[0], v_reg[1], wx_reg[3]);
            i2_reg  <= vn2c_pkg::blend(v_reg[2], v_reg[3], wx_reg[3]);
            out_reg <= vn2c_pkg::blend(i1_reg, i2_reg, wy_reg[4]);
        end
    end

    assign m_valid       = vld_reg[NSTG-1];
    assign m_noise_value = out_reg;

    `VN_NEVER(a_stall_blocks_input, m_valid && !m_ready && s_ready, "input open in stall")
    `VN_ASSERT(a_stall_holds_valid, !en |=> $stable(vld_reg), "stage valid bits moved during stall")
    `VN_ASSERT(a_accept_enters, s_valid && s_ready |=> vld_reg[0], "accepted beat not in first stage")
    `VN_ASSERT(a_cfg_write, cfg_valid && cfg_ready |=> freq_reg == $past(cfg_data), "cfg write lost")

endmodule

[rtl/vn2c_cos_rom.sv]
// Two-port cosine ROM with registered read data.
// Depends on vn2c_pkg for the table contents.
module vn2c_cos_rom (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [vn2c_pkg::ROM_AW-1:0]       addr_a,
    input  logic [vn2c_pkg::ROM_AW-1:0]       addr_b,
    output logic signed [vn2c_pkg::COS_W-1:0] data_a,
    output logic signed [vn2c_pkg::COS_W-1:0] data_b
);
    localparam vn2c_pkg::cos_table_t COS_TABLE = vn2c_pkg::build_cos_table();

    logic signed [vn2c_pkg::COS_W-1:0] data_a_reg, data_b_reg;

    // Read both ports on advance
    always_ff @(posedge aclk) begin
        if (en) begin
            data_a_reg <= COS_TABLE[addr_a];
            data_b_reg <= COS_TABLE[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;
endmodule

[rtl/vn2c_hash.sv]
// Four-stage lattice hash pipeline: index, square, polynomial, final product.
// Depends on vn2c_pkg for the noise width.
module vn2c_hash (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [31:0]                  px,
    input  logic [31:0]                  py,
    output logic [vn2c_pkg::NOISE_W-1:0] hash
);
    logic [31:0] n_next, n0;
    logic [31:0] n_reg, n2_reg, n3_reg;
    logic [31:0] sq_reg, t_reg;
    logic [31:0] h_full;
    logic [vn2c_pkg::NOISE_W-1:0] hash_reg;

    // Fold lattice point into one word and scramble
    assign n0     = py * 32'd57 + px;
    assign n_next = n0 ^ (n0 << 13);
    assign h_full = n3_reg * t_reg + 32'd1376312589;

    // Advance the multiply chain
    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg    <= n_next;
            sq_reg   <= n_reg * n_reg;
            n2_reg   <= n_reg;
            t_reg    <= sq_reg * 32'd15731 + 32'd789221;
            n3_reg   <= n2_reg;
            hash_reg <= h_full[26:19];
        end
    end

    assign hash = hash_reg;
endmodule
